FILE: rtl/ger_pkg.sv
// shared constants, types and helpers for the gear event recorder
package ger_pkg;

  localparam int LOG_DEPTH    = 10;
  localparam int RECORD_BYTES = 12;
  localparam int REC_W        = RECORD_BYTES * 8;
  localparam int SLOT_W       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int COUNT_W      = $clog2(LOG_DEPTH + 1);
  localparam int IDX_W        = 4;
  localparam int SUM_W        = ((COUNT_W > IDX_W) ? COUNT_W : IDX_W) + 1;
  localparam int BYTE_W       = $clog2(RECORD_BYTES);
  localparam int GEAR_W       = 4;
  localparam int FUNC_W       = 3;
  localparam int STAT_W       = 2;
  localparam int ADC_W        = 10;
  localparam int SPEED_W      = 7;

  // speed = floor(adc * 10 / 103) as a reciprocal multiply, exact over the adc range
  localparam int            SPEED_MULT_W = 17;
  localparam int            SPEED_SHIFT  = 20;
  localparam int            SPEED_PROD_W = ADC_W + SPEED_MULT_W;
  localparam logic [16:0]   SPEED_MULT   = 17'd101810;
  // tens digit of a value below one hundred
  localparam logic [7:0]    TENS_MULT    = 8'd205;
  localparam int            TENS_SHIFT   = 11;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_COLON = 8'h3A;

  localparam logic [GEAR_W-1:0] GEAR_ON   = 4'd0;
  localparam logic [GEAR_W-1:0] GEAR_GN   = 4'd1;
  localparam logic [GEAR_W-1:0] GEAR_GR   = 4'd7;
  localparam logic [GEAR_W-1:0] GEAR_COLL = 4'd8;

  localparam logic [FUNC_W-1:0] FN_RECORD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_COLLISION = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GEAR_UP   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GEAR_DOWN = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BYTE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_REPLY,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_W-1:0]    waddr;
    logic [REC_W-1:0]     wdata;
    logic                 re;
    logic [SLOT_W-1:0]    raddr;
  } mem_req_t;

  // two-character gear code, second selects the right-hand character
  function automatic logic [7:0] gear_char(input logic [GEAR_W-1:0] gear, input logic second);
    logic [7:0] c0;
    logic [7:0] c1;
    c0 = "C";
    c1 = "_";
    case (gear)
      4'd0:    begin c0 = "O"; c1 = "N"; end
      4'd1:    begin c0 = "G"; c1 = "N"; end
      4'd2:    begin c0 = "G"; c1 = "1"; end
      4'd3:    begin c0 = "G"; c1 = "2"; end
      4'd4:    begin c0 = "G"; c1 = "3"; end
      4'd5:    begin c0 = "G"; c1 = "4"; end
      4'd6:    begin c0 = "G"; c1 = "5"; end
      4'd7:    begin c0 = "G"; c1 = "R"; end
      default: begin c0 = "C"; c1 = "_"; end
    endcase
    return second ? c1 : c0;
  endfunction

endpackage

FILE: rtl/ger_in_if.sv
// request channel of the gear event recorder
interface ger_in_if;
  logic                       valid;
  logic                       ready;
  logic [ger_pkg::FUNC_W-1:0] func;
  logic [7:0]                 rtc_hours;
  logic [7:0]                 rtc_minutes;
  logic [7:0]                 rtc_seconds;
  logic [ger_pkg::ADC_W-1:0]  speed_adc;
  logic [ger_pkg::IDX_W-1:0]  entry_index;

  modport source (
    output valid, func, rtc_hours, rtc_minutes, rtc_seconds, speed_adc, entry_index,
    input  ready
  );
  modport sink (
    input  valid, func, rtc_hours, rtc_minutes, rtc_seconds, speed_adc, entry_index,
    output ready
  );
endinterface

FILE: rtl/ger_out_if.sv
// result channel of the gear event recorder
interface ger_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        last;
  logic [ger_pkg::STAT_W-1:0]  status;
  logic [ger_pkg::GEAR_W-1:0]  gear_code;
  logic [3:0]                  log_count;

  modport source (
    output valid, out_byte, last, status, gear_code, log_count,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last, status, gear_code, log_count,
    output ready
  );
endinterface

FILE: rtl/gear_event_recorder.sv
// top level of the gear event recorder: control, gear state and result register
//
// usage
//   req carries one request per handshake (valid and ready both high): a func code
//   plus the raw rtc hour, minute and second registers, a speed sample and an entry
//   index. res returns the results of each request, the final one marked by last.
//   record, collision, gear up and gear down store a twelve-byte ascii record
//   (hh:mm:ss, gear code, two speed digits) and answer with one done result.
//   read returns the twelve bytes of the chosen record, oldest first, or one
//   out-of-range result; clear empties the log and answers done.
// timing
//   a storing request goes through capture and speed multiply, memory write and
//   result load. a read fetches one row from the record memory, then sends one byte
//   per cycle from the registered row while res can take it; others just load.
//   req.ready is high only while no request is in flight.
// reset
//   rst (synchronous) returns the gear to ON, clears the collision flag and
//   empties the log; record memory contents are not cleared.
// back-pressure
//   results sit in a single output register; while res.ready is low that register
//   holds and the byte stream pauses. a new request may be taken while the last
//   result of the previous one still waits.
module gear_event_recorder (
  input  logic      clk,
  input  logic      rst,
  ger_in_if.sink    req,
  ger_out_if.source res
);

  ger_pkg::state_t                 state;
  ger_pkg::state_t                 state_next;

  logic [ger_pkg::GEAR_W-1:0]      gear_index;
  logic [ger_pkg::GEAR_W-1:0]      gear_next;
  logic                            collision_flag;
  logic                            collision_next;
  logic [ger_pkg::SLOT_W-1:0]      oldest_slot;
  logic [ger_pkg::COUNT_W-1:0]     record_count;
  logic [ger_pkg::BYTE_W-1:0]      byte_cnt;
  logic [ger_pkg::STAT_W-1:0]      reply_status;
  logic [ger_pkg::STAT_W-1:0]      reply_status_next;

  // result register
  logic                            out_valid;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic [ger_pkg::STAT_W-1:0]      out_status;
  logic [ger_pkg::GEAR_W-1:0]      out_gear;
  logic [3:0]                      out_count;

  // control decode
  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic [7:0]                      load_byte;
  logic                            load_last;
  logic [ger_pkg::STAT_W-1:0]      load_status;
  logic                            gear_we;
  logic                            fmt_start;
  logic                            log_append;
  logic                            log_clear;
  logic                            byte_step;
  logic                            in_range;
  logic                            log_full;

  logic [ger_pkg::SUM_W-1:0]       rd_sum;
  logic [ger_pkg::SLOT_W-1:0]      rd_slot;
  logic [ger_pkg::SUM_W-1:0]       wr_sum;
  logic [ger_pkg::SLOT_W-1:0]      wr_slot;
  logic [ger_pkg::SLOT_W-1:0]      oldest_inc;

  logic [ger_pkg::REC_W-1:0]       record;
  logic [ger_pkg::REC_W-1:0]       rd_data;
  ger_pkg::mem_req_t               mreq;

  // requests are taken only while idle
  assign req.ready = (state == ger_pkg::S_IDLE);
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;
  assign log_full = (record_count == ger_pkg::COUNT_W'(ger_pkg::LOG_DEPTH));

  // read bound and row address; for an in-range read the sum stays below twice the depth
  assign in_range = ger_pkg::SUM_W'(req.entry_index) < ger_pkg::SUM_W'(record_count);
  assign rd_sum   = ger_pkg::SUM_W'(oldest_slot) + ger_pkg::SUM_W'(req.entry_index);
  assign rd_slot  = (rd_sum >= ger_pkg::SUM_W'(ger_pkg::LOG_DEPTH)) ?
                    ger_pkg::SLOT_W'(rd_sum - ger_pkg::SUM_W'(ger_pkg::LOG_DEPTH)) :
                    ger_pkg::SLOT_W'(rd_sum);

  // append slot: next free row, or the oldest row once the log is full
  assign wr_sum   = ger_pkg::SUM_W'(oldest_slot) + ger_pkg::SUM_W'(record_count);
  assign wr_slot  = log_full ? oldest_slot :
                    (wr_sum >= ger_pkg::SUM_W'(ger_pkg::LOG_DEPTH)) ?
                    ger_pkg::SLOT_W'(wr_sum - ger_pkg::SUM_W'(ger_pkg::LOG_DEPTH)) :
                    ger_pkg::SLOT_W'(wr_sum);
  assign oldest_inc = (oldest_slot == ger_pkg::SLOT_W'(ger_pkg::LOG_DEPTH - 1)) ?
                      '0 : oldest_slot + 1'b1;

  // gear transitions
  always_comb begin
    gear_next      = gear_index;
    collision_next = collision_flag;
    case (req.func)
      ger_pkg::FN_COLLISION: begin
        gear_next      = ger_pkg::GEAR_COLL;
        collision_next = 1'b1;
      end
      ger_pkg::FN_GEAR_UP: begin
        // out of a collision the climb starts from ON, so it lands on GN
        gear_next = collision_flag ? ger_pkg::GEAR_ON : gear_index;
        if (gear_next < ger_pkg::GEAR_GR) begin
          gear_next = gear_next + 1'b1;
        end
        collision_next = 1'b0;
      end
      ger_pkg::FN_GEAR_DOWN: begin
        gear_next = collision_flag ? ger_pkg::GEAR_GN : gear_index;
        if (gear_next > ger_pkg::GEAR_GN) begin
          gear_next = gear_next - 1'b1;
        end
        collision_next = 1'b0;
      end
      default: begin
        gear_next      = gear_index;
        collision_next = collision_flag;
      end
    endcase
  end

  // next state and control
  always_comb begin
    state_next        = state;
    reply_status_next = reply_status;
    gear_we           = 1'b0;
    fmt_start         = 1'b0;
    log_append        = 1'b0;
    log_clear         = 1'b0;
    byte_step         = 1'b0;
    out_load          = 1'b0;
    load_byte         = '0;
    load_last         = 1'b1;
    load_status       = reply_status;
    mreq              = '0;
    mreq.raddr        = rd_slot;
    mreq.waddr        = wr_slot;
    mreq.wdata        = record;
    case (state)
      ger_pkg::S_IDLE: begin
        if (accept) begin
          case (req.func) inside
            ger_pkg::FN_RECORD, ger_pkg::FN_COLLISION,
            ger_pkg::FN_GEAR_UP, ger_pkg::FN_GEAR_DOWN: begin
              gear_we    = 1'b1;
              fmt_start  = 1'b1;
              state_next = ger_pkg::S_WRITE;
            end
            ger_pkg::FN_READ: begin
              if (in_range) begin
                mreq.re    = 1'b1;
                state_next = ger_pkg::S_STREAM;
              end else begin
                reply_status_next = ger_pkg::STAT_RANGE;
                state_next        = ger_pkg::S_REPLY;
              end
            end
            ger_pkg::FN_CLEAR: begin
              log_clear         = 1'b1;
              reply_status_next = ger_pkg::STAT_DONE;
              state_next        = ger_pkg::S_REPLY;
            end
            default: begin
              // unused codes only acknowledge
              reply_status_next = ger_pkg::STAT_DONE;
              state_next        = ger_pkg::S_REPLY;
            end
          endcase
        end
      end
      ger_pkg::S_WRITE: begin
        mreq.we           = 1'b1;
        log_append        = 1'b1;
        reply_status_next = ger_pkg::STAT_DONE;
        state_next        = ger_pkg::S_REPLY;
      end
      ger_pkg::S_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ger_pkg::S_IDLE;
        end
      end
      ger_pkg::S_STREAM: begin
        load_status = ger_pkg::STAT_BYTE;
        load_byte   = rd_data[byte_cnt*8 +: 8];
        load_last   = (byte_cnt == ger_pkg::BYTE_W'(ger_pkg::RECORD_BYTES - 1));
        if (out_free) begin
          out_load  = 1'b1;
          byte_step = 1'b1;
          if (load_last) begin
            state_next = ger_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = ger_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ger_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // gear, log pointers and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      gear_index     <= ger_pkg::GEAR_ON;
      collision_flag <= 1'b0;
      oldest_slot    <= '0;
      record_count   <= '0;
      byte_cnt       <= '0;
      reply_status   <= ger_pkg::STAT_DONE;
    end else begin
      reply_status <= reply_status_next;
      if (gear_we) begin
        gear_index     <= gear_next;
        collision_flag <= collision_next;
      end
      if (log_clear) begin
        oldest_slot  <= '0;
        record_count <= '0;
      end else if (log_append) begin
        if (log_full) begin
          oldest_slot <= oldest_inc;
        end else begin
          record_count <= record_count + 1'b1;
        end
      end
      if (byte_step) begin
        byte_cnt <= load_last ? '0 : byte_cnt + 1'b1;
      end
    end
  end

  // output register, parts the result side from the request side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte   <= load_byte;
      out_last   <= load_last;
      out_status <= load_status;
      out_gear   <= gear_index;
      out_count  <= record_count[3:0];
    end
  end

  assign res.valid     = out_valid;
  assign res.out_byte  = out_byte;
  assign res.last      = out_last;
  assign res.status    = out_status;
  assign res.gear_code = out_gear;
  assign res.log_count = out_count;

  ger_rec_fmt u_fmt (
    .clk       (clk),
    .start     (fmt_start),
    .hours     (req.rtc_hours),
    .minutes   (req.rtc_minutes),
    .seconds   (req.rtc_seconds),
    .speed_adc (req.speed_adc),
    .gear      (gear_next),
    .record    (record)
  );

  ger_log_mem u_mem (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  // the log never holds more records than it has rows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= ger_pkg::COUNT_W'(ger_pkg::LOG_DEPTH))
    else $error("record count beyond log depth");

  // oldest pointer stays on a real row
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    oldest_slot <= ger_pkg::SLOT_W'(ger_pkg::LOG_DEPTH - 1))
    else $error("oldest slot beyond log depth");

  // a pending collision always shows as the collision gear
  a_collision_gear: assert property (@(posedge clk) disable iff (rst)
    collision_flag |-> (gear_index == ger_pkg::GEAR_COLL))
    else $error("collision flag without collision gear");

  // an in-range read goes straight to streaming from the first byte
  a_read_stream: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == ger_pkg::FN_READ) && in_range) |=>
      (state == ger_pkg::S_STREAM) && (byte_cnt == '0))
    else $error("read did not start a byte stream");

  // a full log keeps its count when a record is appended
  a_full_append: assert property (@(posedge clk) disable iff (rst)
    (log_append && log_full) |=> log_full)
    else $error("append to full log changed the count");

endmodule

FILE: rtl/ger_log_mem.sv
// record memory, one record per row, registered read
module ger_log_mem (
  input  logic                        clk,
  input  ger_pkg::mem_req_t           mreq,
  output logic [ger_pkg::REC_W-1:0]   rd_data
);

  logic [ger_pkg::REC_W-1:0] mem [ger_pkg::LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rd_data <= mem[mreq.raddr];
    end
  end

endmodule

FILE: rtl/ger_rec_fmt.sv
// captures an event and builds its ascii record
module ger_rec_fmt (
  input  logic                        clk,
  input  logic                        start,
  input  logic [7:0]                  hours,
  input  logic [7:0]                  minutes,
  input  logic [7:0]                  seconds,
  input  logic [ger_pkg::ADC_W-1:0]   speed_adc,
  input  logic [ger_pkg::GEAR_W-1:0]  gear,
  output logic [ger_pkg::REC_W-1:0]   record
);

  logic [ger_pkg::SPEED_PROD_W-1:0] speed_prod;
  logic [ger_pkg::SPEED_W-1:0]      speed;
  logic [7:0]                       hours_q;
  logic [7:0]                       minutes_q;
  logic [7:0]                       seconds_q;
  logic [ger_pkg::GEAR_W-1:0]       gear_q;
  logic [14:0]                      tens_prod;
  logic [3:0]                       tens;
  logic [ger_pkg::SPEED_W-1:0]      ones_full;
  logic [1:0]                       hour_tens;

  assign speed_prod = ger_pkg::SPEED_PROD_W'(speed_adc) *
                      ger_pkg::SPEED_PROD_W'(ger_pkg::SPEED_MULT);

  always_ff @(posedge clk) begin
    if (start) begin
      speed     <= speed_prod[ger_pkg::SPEED_SHIFT +: ger_pkg::SPEED_W];
      hours_q   <= hours;
      minutes_q <= minutes;
      seconds_q <= seconds;
      gear_q    <= gear;
    end
  end

  // split speed into two decimal digits
  assign tens_prod = 15'(speed) * 15'(ger_pkg::TENS_MULT);
  assign tens      = tens_prod[ger_pkg::TENS_SHIFT +: 4];
  assign ones_full = speed - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);

  // 12-hour mode keeps only one tens bit
  assign hour_tens = hours_q[6] ? {1'b0, hours_q[4]} : hours_q[5:4];

  always_comb begin
    record          = '0;
    record[0*8 +: 8]  = ger_pkg::ASCII_ZERO + {6'd0, hour_tens};
    record[1*8 +: 8]  = ger_pkg::ASCII_ZERO + {4'd0, hours_q[3:0]};
    record[2*8 +: 8]  = ger_pkg::ASCII_COLON;
    record[3*8 +: 8]  = ger_pkg::ASCII_ZERO + {4'd0, minutes_q[7:4]};
    record[4*8 +: 8]  = ger_pkg::ASCII_ZERO + {4'd0, minutes_q[3:0]};
    record[5*8 +: 8]  = ger_pkg::ASCII_COLON;
    record[6*8 +: 8]  = ger_pkg::ASCII_ZERO + {4'd0, seconds_q[7:4]};
    record[7*8 +: 8]  = ger_pkg::ASCII_ZERO + {4'd0, seconds_q[3:0]};
    record[8*8 +: 8]  = ger_pkg::gear_char(gear_q, 1'b0);
    record[9*8 +: 8]  = ger_pkg::gear_char(gear_q, 1'b1);
    record[10*8 +: 8] = ger_pkg::ASCII_ZERO + {4'd0, tens};
    record[11*8 +: 8] = ger_pkg::ASCII_ZERO + {4'd0, ones_full[3:0]};
  end

endmodule
